/* rtl/upwind_convection_stencil_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the upwind convection stencil
// Concurrent checks in simulation, empty bodies under synthesis.
// ----------------------------------------------------------------------------
`ifndef UPWIND_CONVECTION_STENCIL_MACROS_SVH
`define UPWIND_CONVECTION_STENCIL_MACROS_SVH

`ifndef SYNTHESIS
// Property holds at every clock while out of reset.
`define UCS_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("stencil check failed");
// Condition in this cycle implies the consequence in the next one.
`define UCS_ASSERT_NEXT(name, clk, rst_n, cond, nxt) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
    else $error("stencil sequence check failed");
`else
`define UCS_ASSERT(name, clk, rst_n, prop)
`define UCS_ASSERT_NEXT(name, clk, rst_n, cond, nxt)
`endif

`endif

/* rtl/ucs_pkg.sv */
// ----------------------------------------------------------------------------
// ucs_pkg
// Widths, register indexes and shared types of the upwind convection stencil.
// ----------------------------------------------------------------------------
package ucs_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_WIDTH   = 1024;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = 16;
  localparam int GW_W        = 11;
  localparam int COEF_W      = 16;
  localparam int FRAC_W      = 16;
  localparam int DIFF_W      = SAMPLE_BITS + 1;
  localparam int PROD_W      = DIFF_W + COEF_W + 1;
  localparam int ACC_W       = PROD_W + 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TWO_DIM  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_X   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_Y   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOUNDARY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_W   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_H   = 3'd5;

  localparam logic [GW_W-1:0]        GRID_W_RST   = GW_W'(1024);
  localparam logic [ROW_W-1:0]       GRID_H_RST   = ROW_W'(1024);
  localparam logic [SAMPLE_BITS-1:0] BOUNDARY_RST = SAMPLE_BITS'(4096);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // per-stage control travelling with a word
  typedef struct packed {
    logic valid;
    logic edge_cell;   // 2D edge: word is the boundary value
    logic two_dim;
    logic grid_end;
  } ucs_ctl_t;

endpackage

/* rtl/ucs_in_if.sv */
// ----------------------------------------------------------------------------
// ucs_in_if
// Input channel: one grid sample per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ucs_in_if import ucs_pkg::*;;
  logic    valid;
  logic    ready;
  sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

/* rtl/ucs_out_if.sv */
// ----------------------------------------------------------------------------
// ucs_out_if
// Result channel: updated sample and grid end flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ucs_out_if import ucs_pkg::*;;
  logic    valid;
  logic    ready;
  sample_t sample_out;
  logic    grid_end;

  modport source (output valid, output sample_out, output grid_end, input ready);
  modport sink   (input valid, input sample_out, input grid_end, output ready);
endinterface

/* rtl/upwind_convection_stencil.sv */
// ----------------------------------------------------------------------------
// upwind_convection_stencil
// One time step of first-order upwind linear convection over a raster grid.
// ----------------------------------------------------------------------------
// Samples (signed Q3.12) arrive in raster order, one word per cycle, and each
// gives one updated word for the same position through the input and result registers:
// u - coef_x*(u - left), plus - coef_y*(u - above) in 2D mode, rounded half
// up and saturated to 16 bits. In 2D mode the edge cells return
// boundary_value; in 1D mode the first point of a row uses boundary_value as
// its left neighbour. The block takes one word per cycle while the result
// side keeps up; the whole pipe (line store read and input register, result
// register) advances together and stops only when the result register is
// full and not taken. The line store is a 1024 x 16 memory with one
// read-before-write access per word, so the sample above is read in the same
// cycle the current sample replaces it. Write configuration only while the
// block is idle; row and column counters carry on across writes.
// ----------------------------------------------------------------------------
`include "upwind_convection_stencil_macros.svh"

module upwind_convection_stencil import ucs_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  ucs_in_if.sink                in_i,
  ucs_out_if.source             out_o
);

  // ---------------- configuration registers ----------------
  logic              two_dim_q;
  logic [COEF_W-1:0] coef_x_q;
  logic [COEF_W-1:0] coef_y_q;
  sample_t           boundary_q;
  logic [GW_W-1:0]   grid_w_q;
  logic [ROW_W-1:0]  grid_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      two_dim_q  <= 1'b0;
      coef_x_q   <= '0;
      coef_y_q   <= '0;
      boundary_q <= BOUNDARY_RST;
      grid_w_q   <= GRID_W_RST;
      grid_h_q   <= GRID_H_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TWO_DIM:  two_dim_q  <= cfg_data_i[0];
        REG_COEF_X:   coef_x_q   <= cfg_data_i[COEF_W-1:0];
        REG_COEF_Y:   coef_y_q   <= cfg_data_i[COEF_W-1:0];
        REG_BOUNDARY: boundary_q <= cfg_data_i[SAMPLE_BITS-1:0];
        REG_GRID_W:   grid_w_q   <= cfg_data_i[GW_W-1:0];
        REG_GRID_H:   grid_h_q   <= cfg_data_i[ROW_W-1:0];
        default: ;    // unused indexes are ignored
      endcase
    end
  end

  // ---------------- pipe control ----------------
  // Everything moves when the result register is free or being taken.
  logic en;
  logic in_acc;

  assign en         = !out_o.valid || out_o.ready;
  assign in_i.ready = en;
  assign in_acc     = in_i.valid && en;

  // ---------------- raster position ----------------
  logic [COL_W-1:0] col_q, col_c, wlast;
  logic [ROW_W-1:0] row_q, hlast;
  logic             last_col, last_row, edge_c;
  sample_t          left_q, left_c;

  // clamp width to 2..MAX_WIDTH, height to at least 1
  always_comb begin
    if (grid_w_q < GW_W'(2)) begin
      wlast = COL_W'(1);
    end else if (grid_w_q > GW_W'(MAX_WIDTH)) begin
      wlast = COL_W'(MAX_WIDTH - 1);
    end else begin
      wlast = COL_W'(grid_w_q - GW_W'(1));
    end
    hlast = (grid_h_q == '0) ? '0 : grid_h_q - ROW_W'(1);
  end

  // a column past the end counts as the last one
  assign last_col = col_q >= wlast;
  assign col_c    = last_col ? wlast : col_q;
  assign last_row = row_q >= hlast;
  assign edge_c   = two_dim_q &&
                    ((col_c == '0) || last_col || (row_q == '0) || last_row);
  assign left_c   = (!two_dim_q && col_c == '0) ? boundary_q : left_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      left_q <= '0;
    end else if (in_acc) begin
      left_q <= in_i.sample_in;
      if (last_col) begin
        col_q <= '0;
        row_q <= last_row ? '0 : row_q + ROW_W'(1);
      end else begin
        col_q <= col_c + COL_W'(1);
      end
    end
  end

  // ---------------- line store ----------------
  // Read-before-write: above_q gets the previous row's sample at this column.
  sample_t row_mem [MAX_WIDTH];
  sample_t above_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      above_q         <= row_mem[col_c];
      row_mem[col_c]  <= in_i.sample_in;
    end
  end

  // ---------------- input stage ----------------
  ucs_ctl_t s1_ctl_q;
  sample_t  u1_q, left1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_ctl_q <= '0;
    end else if (en) begin
      s1_ctl_q.valid     <= in_i.valid;
      s1_ctl_q.edge_cell <= edge_c;
      s1_ctl_q.two_dim   <= two_dim_q;
      s1_ctl_q.grid_end  <= last_col && last_row;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      u1_q    <= in_i.sample_in;
      left1_q <= left_c;
    end
  end

  // ---------------- arithmetic and result register ----------------
  ucs_update u_update (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .ctl_i      (s1_ctl_q),
    .u_i        (u1_q),
    .left_i     (left1_q),
    .above_i    (above_q),
    .coef_x_i   (coef_x_q),
    .coef_y_i   (coef_y_q),
    .boundary_i (boundary_q),
    .out_o      (out_o)
  );

  // ---------------- checks ----------------
  // last point of the grid sends both counters home
  `UCS_ASSERT_NEXT(a_grid_wrap, clk_i, rst_ni, in_acc && last_col && last_row, col_q == '0 && row_q == '0)
  // inside a row the column steps by one
  `UCS_ASSERT_NEXT(a_col_step, clk_i, rst_ni, in_acc && !last_col, col_q == $past(col_c) + COL_W'(1))
  // a held result freezes the input stage
  `UCS_ASSERT_NEXT(a_stall_hold, clk_i, rst_ni, out_o.valid && !out_o.ready, $stable(s1_ctl_q))

endmodule

/* rtl/ucs_update.sv */
// ----------------------------------------------------------------------------
// ucs_update
// Weighted differences, rounding and saturation; drives the result register.
// ----------------------------------------------------------------------------
module ucs_update import ucs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  ucs_ctl_t          ctl_i,
  input  sample_t           u_i,
  input  sample_t           left_i,
  input  sample_t           above_i,
  input  logic [COEF_W-1:0] coef_x_i,
  input  logic [COEF_W-1:0] coef_y_i,
  input  sample_t           boundary_i,
  ucs_out_if.source         out_o
);

  localparam int RND_W = ACC_W - FRAC_W;
  localparam logic signed [RND_W-1:0] RMAX = RND_W'(2 ** (SAMPLE_BITS - 1) - 1);
  localparam logic signed [RND_W-1:0] RMIN = -RND_W'(2 ** (SAMPLE_BITS - 1));
  localparam logic signed [ACC_W-1:0] HALF = ACC_W'(2 ** (FRAC_W - 1));

  // weighted differences
  logic signed [DIFF_W-1:0]   diff_x, diff_y;
  logic signed [COEF_W:0]     cx_s, cy_s;
  logic signed [PROD_W-1:0]   prod_x, prod_y;

  assign diff_x = DIFF_W'(u_i) - DIFF_W'(left_i);
  assign diff_y = DIFF_W'(u_i) - DIFF_W'(above_i);
  assign cx_s   = {1'b0, coef_x_i};
  assign cy_s   = {1'b0, coef_y_i};

  always_comb begin
    prod_x = cx_s * diff_x;
    prod_y = '0;
    if (ctl_i.two_dim) begin
      prod_y = cy_s * diff_y;
    end
  end

  // sum, round half up, saturate
  logic signed [ACC_W-1:0] acc;
  logic signed [RND_W-1:0] rnd;
  sample_t                 res_d;
  sample_t                 res_q;
  logic                    end_q;
  logic                    valid_q;

  always_comb begin
    acc = (ACC_W'(u_i) <<< FRAC_W) - ACC_W'(prod_x) - ACC_W'(prod_y) + HALF;
    rnd = acc[ACC_W-1:FRAC_W];
    if (ctl_i.edge_cell) begin
      res_d = boundary_i;
    end else if (rnd > RMAX) begin
      res_d = RMAX[SAMPLE_BITS-1:0];
    end else if (rnd < RMIN) begin
      res_d = RMIN[SAMPLE_BITS-1:0];
    end else begin
      res_d = rnd[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i && ctl_i.valid) begin
      res_q <= res_d;
      end_q <= ctl_i.grid_end;
    end
  end

  assign out_o.valid      = valid_q;
  assign out_o.sample_out = res_q;
  assign out_o.grid_end   = end_q;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: upwind convection stencil testbench
// Streams grids through the stencil in 1D and 2D mode. A local predictor
// tracks the line store, the left neighbor and the raster counters, and
// checks every updated word field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
  import ucs_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned RANDOM_WORDS = 150;

  // register indexes with no register behind them, writes are dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  // values of the mode register
  localparam logic [CFG_DATA_W-1:0] MODE_1D = 16'd0;
  localparam logic [CFG_DATA_W-1:0] MODE_2D = 16'd1;

  typedef struct {
    sample_t value;
    logic    grid_end;
  } update_t;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  ucs_in_if  in_if ();
  ucs_out_if out_if ();

  upwind_convection_stencil u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #5 clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor state: a private copy of the line store, neighbor, counters and
  // registers. Updated when a word is taken or a register is written.
  // --------------------------------------------------------------------------
  sample_t              line_mem [MAX_WIDTH];
  sample_t              prev_word;
  int unsigned          col_pos;
  int unsigned          row_pos;
  logic                 mode_2d;
  logic [COEF_W-1:0]    coef_x_q;
  logic [COEF_W-1:0]    coef_y_q;
  sample_t              boundary_q;
  logic [GW_W-1:0]      width_q;
  logic [ROW_W-1:0]     height_q;

  update_t              updates_q [$];   // predicted words, oldest first

  logic                 quiet = 1'b0;    // no idling on either side
  int unsigned          stall_left = 0;
  int unsigned          cycles = 0;
  int unsigned          words_sent = 0;
  int unsigned          updates_checked = 0;
  int unsigned          grids_seen = 0;
  int unsigned          regs_written = 0;
  int unsigned          mismatches = 0;

  task automatic reset_predictor();
    foreach (line_mem[i]) line_mem[i] = '0;
    prev_word  = '0;
    col_pos    = 0;
    row_pos    = 0;
    mode_2d    = 1'b0;
    coef_x_q   = '0;
    coef_y_q   = '0;
    boundary_q = sample_t'(BOUNDARY_RST);
    width_q    = GRID_W_RST;
    height_q   = GRID_H_RST;
  endtask

  // One upwind step for the word at the current raster position.
  function automatic update_t convect_step(sample_t u);
    int unsigned w;
    int unsigned h;
    int unsigned col;
    logic        last_col;
    logic        last_row;
    logic        is_border;
    longint      acc;
    longint      res;
    longint      hi;
    longint      lo;
    sample_t     left_v;
    update_t     r;
    w = width_q;
    h = height_q;
    if (w < 2) w = 2;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    if (h < 1) h = 1;
    // counters carry over register writes: past the end means at the end
    col      = col_pos;
    last_col = (col >= w - 1);
    if (col > w - 1) col = w - 1;
    last_row = (row_pos >= h - 1);

    if (mode_2d) begin
      is_border = (col == 0) || last_col || (row_pos == 0) || last_row;
      if (is_border) begin
        res = boundary_q;
      end else begin
        acc = longint'(u) * 65536
            - longint'(coef_x_q) * (longint'(u) - longint'(prev_word))
            - longint'(coef_y_q) * (longint'(u) - longint'(line_mem[col]));
        res = (acc + 32768) >>> 16;   // round half up
      end
    end else begin
      // first point of a row has the boundary value on its left
      left_v = (col == 0) ? boundary_q : prev_word;
      acc = longint'(u) * 65536 - longint'(coef_x_q) * (longint'(u) - longint'(left_v));
      res = (acc + 32768) >>> 16;
    end

    hi = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
    lo = -hi - 1;
    if (res > hi) res = hi;
    if (res < lo) res = lo;

    line_mem[col] = u;
    prev_word     = u;
    r.value    = sample_t'(res);
    r.grid_end = last_col && last_row;

    if (last_col) begin
      col_pos = 0;
      row_pos = last_row ? 0 : ((row_pos + 1) & 32'hFFFF);
    end else begin
      col_pos = col + 1;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Random picks
  // --------------------------------------------------------------------------
  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(0, 9))
      0:       return sample_t'(16'h7FFF);
      1:       return sample_t'(16'h8000);
      2:       return sample_t'(int'($urandom_range(0, 8)) - 4);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_coef();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3, 4:    return CFG_DATA_W'($urandom_range(0, 16'h4000));  // stable CFL range
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  // stray bits above the 11-bit width field are left random
  function automatic logic [CFG_DATA_W-1:0] pick_width();
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'($urandom);
    case ($urandom_range(0, 19))
      0:       d[GW_W-1:0] = GW_W'($urandom_range(0, 1));
      1:       d[GW_W-1:0] = GW_W'($urandom_range(13, 64));
      default: d[GW_W-1:0] = GW_W'($urandom_range(2, 12));
    endcase
    return d;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_height();
    if ($urandom_range(0, 15) == 0) return '0;
    return CFG_DATA_W'($urandom_range(1, 6));
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  // Register write while the block is idle; the predictor follows at once.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      REG_TWO_DIM:  mode_2d    = data[0];
      REG_COEF_X:   coef_x_q   = data;
      REG_COEF_Y:   coef_y_q   = data;
      REG_BOUNDARY: boundary_q = sample_t'(data);
      REG_GRID_W:   width_q    = data[GW_W-1:0];
      REG_GRID_H:   height_q   = data;
      default: ;
    endcase
    regs_written++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic write_random_reg(int unsigned pick);
    case (pick)
      0:       write_reg(REG_TWO_DIM, CFG_DATA_W'($urandom));
      1:       write_reg(REG_COEF_X, pick_coef());
      2:       write_reg(REG_COEF_Y, pick_coef());
      3:       write_reg(REG_BOUNDARY, pick_sample());
      4:       write_reg(REG_GRID_W, pick_width());
      default: write_reg(REG_GRID_H, pick_height());
    endcase
  endtask

  // Offers one word, optionally after a gap, and returns once it is taken.
  // valid stays high so the next word can follow back to back.
  task automatic send_word(input sample_t s, output logic at_end);
    update_t want;
    if (!quiet && $urandom_range(0, 99) < 20) begin
      in_if.valid <= 1'b0;
      repeat (gap_len()) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.sample_in <= s;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    want = convect_step(s);
    updates_q.insert(updates_q.size(), want);
    at_end = want.grid_end;
    words_sent++;
  endtask

  // Random words until the grid ends, or until max_words when nonzero.
  task automatic run_grid(int unsigned max_words);
    logic        at_end;
    int unsigned n;
    n      = 0;
    at_end = 1'b0;
    while (!at_end && (max_words == 0 || n < max_words)) begin
      send_word(pick_sample(), at_end);
      n++;
    end
  endtask

  // Lowers valid and waits until every predicted word has come back.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (updates_q.size() != 0) @(posedge clk_i);
  endtask

  // Directed words: both rails, one, zero, minus one.
  task automatic send_extremes(int unsigned n);
    sample_t pattern [5];
    logic    at_end;
    pattern = '{sample_t'(16'h7FFF), sample_t'(16'h8000), sample_t'(16'h0001),
                sample_t'(16'h0000), sample_t'(16'hFFFF)};
    for (int unsigned i = 0; i < n; i++) send_word(pattern[i % 5], at_end);
  endtask

  // Checkerboard of the two rails: every interior cell sees the opposite
  // rail left and above, which drives the sum hard into saturation.
  task automatic send_checkerboard(int unsigned w, int unsigned h);
    logic at_end;
    for (int unsigned r = 0; r < h; r++) begin
      for (int unsigned c = 0; c < w; c++) begin
        send_word(((r + c) % 2) ? sample_t'(16'h8000) : sample_t'(16'h7FFF), at_end);
      end
    end
  endtask

  // Result side: ready drops at random, short stalls mostly, some long ones.
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 99) < 15) begin
      stall_left   <= gap_len() - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Checker: sampled on the falling edge, which shows the handshake of the
  // coming rising edge. The sending side pushes on rising edges only, so the
  // two never race.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : check_updates
    update_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (updates_q.size() == 0) begin
        $display("%0t: word with nothing expected: sample_out %0d grid_end %0b",
                 $time, out_if.sample_out, out_if.grid_end);
        mismatches++;
      end else begin
        want = updates_q.pop_front();
        if (out_if.sample_out !== want.value) begin
          $display("%0t: sample_out mismatch: expected %0d, actual %0d",
                   $time, want.value, out_if.sample_out);
          mismatches++;
        end
        if (out_if.grid_end !== want.grid_end) begin
          $display("%0t: grid_end mismatch: expected %0b, actual %0b",
                   $time, want.grid_end, out_if.grid_end);
          mismatches++;
        end
        if (want.grid_end) grids_seen++;
        updates_checked++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles, %0d words still pending",
               $time, cycles, updates_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset registers: 1D, coef_x zero, so every word comes back unchanged.
  task automatic test_reset_defaults();
    send_extremes(5);
    drain();
  endtask

  // Finishes the first row at the widest grid. This writes every line store
  // entry once, so no later 2D read can hit an entry never written.
  task automatic test_row_store_fill();
    quiet = 1'b1;
    write_reg(REG_GRID_H, 16'd1);
    write_reg(REG_COEF_X, 16'hFFFF);
    run_grid(0);
    drain();
    quiet = 1'b0;
  endtask

  // 1D, 2x2 grids: row start takes the boundary on its left, second row
  // restarts, rails on coefficients and boundary. With coef 0x8000 the
  // word 0 after 1 lands exactly on a rounding tie.
  task automatic test_1d_extremes();
    write_reg(REG_GRID_W, 16'd2);
    write_reg(REG_GRID_H, 16'd2);
    write_reg(REG_BOUNDARY, 16'h7FFF);
    send_extremes(4);
    drain();
    write_reg(REG_COEF_X, 16'h8000);
    write_reg(REG_BOUNDARY, 16'h8000);
    send_extremes(4);
    drain();
    write_reg(REG_COEF_X, 16'h0001);
    write_reg(REG_BOUNDARY, 16'h0000);
    send_extremes(4);
    drain();
  endtask

  // 2D: border cells return the boundary, interior saturates both ways.
  task automatic test_2d_edges();
    write_reg(REG_TWO_DIM, MODE_2D);
    write_reg(REG_GRID_W, 16'd4);
    write_reg(REG_GRID_H, 16'd4);
    write_reg(REG_COEF_X, 16'hFFFF);
    write_reg(REG_COEF_Y, 16'hFFFF);
    write_reg(REG_BOUNDARY, 16'h8000);
    send_checkerboard(4, 4);
    drain();
    write_reg(REG_GRID_W, 16'd3);
    write_reg(REG_GRID_H, 16'd3);
    write_reg(REG_COEF_X, 16'h8000);
    write_reg(REG_COEF_Y, 16'h0001);
    write_reg(REG_BOUNDARY, 16'h7FFF);
    send_checkerboard(3, 3);
    drain();
  endtask

  // Out-of-range geometry and ignored register bits.
  task automatic test_odd_geometry();
    // width zero acts as two: in 2D the whole grid is border
    write_reg(REG_GRID_W, 16'd0);
    write_reg(REG_GRID_H, 16'd3);
    run_grid(0);
    drain();
    // only bit 0 of the mode word counts; spare indexes are dropped;
    // width one acts as two and height zero as one
    write_reg(REG_TWO_DIM, 16'hFFFE);
    write_reg(REG_SPARE_6, CFG_DATA_W'($urandom));
    write_reg(REG_SPARE_7, CFG_DATA_W'($urandom));
    write_reg(REG_GRID_W, 16'd1);
    write_reg(REG_GRID_H, 16'd0);
    run_grid(0);
    drain();
    // all-ones width (2047 after the field) acts as 1024, largest height;
    // both are pulled in partway and the counters clamp
    write_reg(REG_GRID_W, 16'hFFFF);
    write_reg(REG_GRID_H, 16'hFFFF);
    run_grid(5);
    drain();
    write_reg(REG_GRID_W, 16'd2);
    run_grid(3);
    drain();
    write_reg(REG_GRID_H, 16'd2);
    run_grid(0);
    drain();
    // same clamp in 2D, row 0 at width 1024, then narrowed to 4
    write_reg(REG_TWO_DIM, MODE_2D);
    write_reg(REG_GRID_W, 16'd1025);
    write_reg(REG_GRID_H, 16'd3);
    run_grid(5);
    drain();
    write_reg(REG_GRID_W, 16'd4);
    run_grid(0);
    drain();
  endtask

  // Register writes in the middle of a grid; counters carry on.
  task automatic test_midgrid_changes();
    write_reg(REG_TWO_DIM, MODE_2D);
    write_reg(REG_GRID_W, 16'd6);
    write_reg(REG_GRID_H, 16'd5);
    write_reg(REG_COEF_X, pick_coef());
    write_reg(REG_COEF_Y, pick_coef());
    write_reg(REG_BOUNDARY, pick_sample());
    run_grid(10);
    drain();
    write_reg(REG_COEF_X, pick_coef());
    write_reg(REG_COEF_Y, pick_coef());
    write_reg(REG_BOUNDARY, pick_sample());
    run_grid(6);
    drain();
    // column 4 is now past the last one
    write_reg(REG_GRID_W, 16'd4);
    run_grid(0);
    drain();
    // 1D turned into 2D partway through
    write_reg(REG_TWO_DIM, MODE_1D);
    write_reg(REG_GRID_W, 16'd5);
    write_reg(REG_GRID_H, 16'd3);
    run_grid(7);
    drain();
    write_reg(REG_TWO_DIM, MODE_2D);
    run_grid(0);
    drain();
    // height dropped below the current row
    write_reg(REG_GRID_W, 16'd3);
    write_reg(REG_GRID_H, 16'd6);
    run_grid(10);
    drain();
    write_reg(REG_GRID_H, 16'd2);
    run_grid(0);
    drain();
  endtask

  // Random settings, whole grids with random content, now and then a grid
  // interrupted by a random register write.
  task automatic test_random_grids();
    int unsigned target;
    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      quiet = ($urandom_range(0, 5) == 0);
      for (int unsigned k = 0; k < 6; k++) begin
        if ($urandom_range(0, 1) != 0) write_random_reg(k);
      end
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 7) == 0) begin
          run_grid($urandom_range(1, 8));
          drain();
          write_random_reg($urandom_range(0, 5));
        end
        run_grid(0);
      end
      drain();
    end
    quiet = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    in_if.valid     = 1'b0;
    in_if.sample_in = '0;
    out_if.ready    = 1'b0;
    reset_predictor();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_row_store_fill();
    test_1d_extremes();
    test_2d_edges();
    test_odd_geometry();
    test_midgrid_changes();
    test_random_grids();

    drain();
    repeat (10) @(posedge clk_i);

    $display("Ran %0d samples through 1D and 2D grids, %0d updated words checked,",
             words_sent, updates_checked);
    $display("%0d grids completed, %0d register writes, %0d mismatches",
             grids_seen, regs_written, mismatches);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
